// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property, masked while reset is high.
`define SLI_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every edge, reset included.
`define SLI_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/sli_pkg.sv =====
// Shared constants and types for the segment/line intersection block.
package sli_pkg;

   // Default coordinate width and fixed port width.
   localparam int COORD_WIDTH = 32;
   localparam int PORT_WIDTH  = 32;

   // Depth of the queue between front and back.
   localparam int QUEUE_DEPTH = 4;

   // Queue status seen by the front and back.
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// ===== hdl/sli_queue.sv =====
// Request queue between the front and the back.
module sli_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = sli_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [WIDTH-1:0]      push_data,
   input  logic                  pop,
   output logic [WIDTH-1:0]      pop_data,
   output sli_pkg::q_status_type status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] ent_ff [0:DEPTH-1];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store the pushed request
   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = ent_ff[rd_ptr_ff];
   assign status.full  = (cnt_ff == CNT_W'(DEPTH));
   assign status.empty = (cnt_ff == '0);

endmodule

// ===== hdl/sli_front.sv =====
// Front: accepts requests, forms line equations and the determinant.
module sli_front #(
   parameter int COORD_WIDTH = sli_pkg::COORD_WIDTH,
   localparam int W  = COORD_WIDTH,
   localparam int AW = W + 1,
   localparam int CW = 2 * W + 2,
   localparam int DW = 2 * W + 3,
   localparam int EW = 4 * AW + 2 * CW + DW + 1 + 4 * W
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [sli_pkg::PORT_WIDTH-1:0]    req_seg_start_x,
   input  logic [sli_pkg::PORT_WIDTH-1:0]    req_seg_start_y,
   input  logic [sli_pkg::PORT_WIDTH-1:0]    req_seg_end_x,
   input  logic [sli_pkg::PORT_WIDTH-1:0]    req_seg_end_y,
   input  logic [sli_pkg::PORT_WIDTH-1:0]    req_line_a_x,
   input  logic [sli_pkg::PORT_WIDTH-1:0]    req_line_a_y,
   input  logic [sli_pkg::PORT_WIDTH-1:0]    req_line_b_x,
   input  logic [sli_pkg::PORT_WIDTH-1:0]    req_line_b_y,
   input  sli_pkg::q_status_type             q_status,
   output logic                              push,
   output logic [EW-1:0]                     push_data
);

   logic fe;
   logic signed [W-1:0] sx_w, sy_w, ex_w, ey_w, ax_w, ay_w, bx_w, by_w;

   // Stage 1: differences
   logic                 v1_ff;
   logic signed [W-1:0]  sx1_ff, sy1_ff, ex1_ff, ey1_ff, ax1_ff, ay1_ff;
   logic signed [AW-1:0] a1_in, b1_in, a2_in, b2_in;
   logic signed [AW-1:0] a1_1_ff, b1_1_ff, a2_1_ff, b2_1_ff;

   // Stage 2: products
   logic                   v2_ff;
   logic signed [W-1:0]    sx2_ff, sy2_ff, ex2_ff, ey2_ff;
   logic signed [AW-1:0]   a1_2_ff, b1_2_ff, a2_2_ff, b2_2_ff;
   logic signed [CW-1:0]   pd1_in, pd2_in, pd1_ff, pd2_ff;
   logic signed [2*W:0]    pc1a_in, pc1b_in, pc2a_in, pc2b_in;
   logic signed [2*W:0]    pc1a_ff, pc1b_ff, pc2a_ff, pc2b_ff;

   // Stage 3: determinant and constants
   logic                   v3_ff;
   logic signed [W-1:0]    sx3_ff, sy3_ff, ex3_ff, ey3_ff;
   logic signed [AW-1:0]   a1_3_ff, b1_3_ff, a2_3_ff, b2_3_ff;
   logic signed [DW-1:0]   det_in, det_ff;
   logic signed [CW-1:0]   c1_in, c2_in, c1_ff, c2_ff;
   logic                   par_in, par_ff;

   // Take the low coordinate bits as two's complement
   assign sx_w = req_seg_start_x[W-1:0];
   assign sy_w = req_seg_start_y[W-1:0];
   assign ex_w = req_seg_end_x[W-1:0];
   assign ey_w = req_seg_end_y[W-1:0];
   assign ax_w = req_line_a_x[W-1:0];
   assign ay_w = req_line_a_y[W-1:0];
   assign bx_w = req_line_b_x[W-1:0];
   assign by_w = req_line_b_y[W-1:0];

   // Hold the pipe while a finished request waits on a full queue
   assign fe        = !(v3_ff && q_status.full);
   assign req_stall = !fe;
   assign push      = v3_ff && !q_status.full;

   always_comb begin
      a1_in = AW'(ey_w) - AW'(sy_w);
      b1_in = AW'(sx_w) - AW'(ex_w);
      a2_in = AW'(by_w) - AW'(ay_w);
      b2_in = AW'(ax_w) - AW'(bx_w);
   end

   always_comb begin
      pd1_in  = a1_1_ff * b2_1_ff;
      pd2_in  = a2_1_ff * b1_1_ff;
      pc1a_in = a1_1_ff * sx1_ff;
      pc1b_in = b1_1_ff * sy1_ff;
      pc2a_in = a2_1_ff * ax1_ff;
      pc2b_in = b2_1_ff * ay1_ff;
   end

   always_comb begin
      det_in = DW'(pd1_ff) - DW'(pd2_ff);
      c1_in  = CW'(pc1a_ff) + CW'(pc1b_ff);
      c2_in  = CW'(pc2a_ff) + CW'(pc2b_ff);
      par_in = (pd1_ff == pd2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (fe) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // Advance the payload stages
   always_ff @(posedge clock) begin
      if (fe) begin
         sx1_ff  <= sx_w;
         sy1_ff  <= sy_w;
         ex1_ff  <= ex_w;
         ey1_ff  <= ey_w;
         ax1_ff  <= ax_w;
         ay1_ff  <= ay_w;
         a1_1_ff <= a1_in;
         b1_1_ff <= b1_in;
         a2_1_ff <= a2_in;
         b2_1_ff <= b2_in;

         sx2_ff  <= sx1_ff;
         sy2_ff  <= sy1_ff;
         ex2_ff  <= ex1_ff;
         ey2_ff  <= ey1_ff;
         a1_2_ff <= a1_1_ff;
         b1_2_ff <= b1_1_ff;
         a2_2_ff <= a2_1_ff;
         b2_2_ff <= b2_1_ff;
         pd1_ff  <= pd1_in;
         pd2_ff  <= pd2_in;
         pc1a_ff <= pc1a_in;
         pc1b_ff <= pc1b_in;
         pc2a_ff <= pc2a_in;
         pc2b_ff <= pc2b_in;

         sx3_ff  <= sx2_ff;
         sy3_ff  <= sy2_ff;
         ex3_ff  <= ex2_ff;
         ey3_ff  <= ey2_ff;
         a1_3_ff <= a1_2_ff;
         b1_3_ff <= b1_2_ff;
         a2_3_ff <= a2_2_ff;
         b2_3_ff <= b2_2_ff;
         det_ff  <= det_in;
         c1_ff   <= c1_in;
         c2_ff   <= c2_in;
         par_ff  <= par_in;
      end
   end

   assign push_data = {a1_3_ff, b1_3_ff, a2_3_ff, b2_3_ff, c1_ff, c2_ff, det_ff, par_ff,
                       sx3_ff, sy3_ff, ex3_ff, ey3_ff};

endmodule

// ===== hdl/sli_div.sv =====
// Pipelined restoring divider: one quotient bit per stage plus an overflow check.
module sli_div #(
   parameter int COORD_WIDTH = sli_pkg::COORD_WIDTH,
   parameter int TAG_W       = 1,
   localparam int W  = COORD_WIDTH,
   localparam int NW = 3 * W + 5,
   localparam int DW = 2 * W + 3
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [NW-1:0]    in_num,
   input  logic [DW-1:0]    in_den,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output logic [W-1:0]     out_quot,
   output logic             out_ovf,
   output logic [TAG_W-1:0] out_tag
);

   logic [NW-1:0]    rem_ff [0:W-1];
   logic [DW-1:0]    den_ff [0:W-1];
   logic [W-1:0]     q_ff   [1:W];
   logic             ovf_ff [0:W];
   logic             v_ff   [0:W];
   logic [TAG_W-1:0] tag_ff [0:W];

   // Flag quotients that do not fit in the coordinate width
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= in_num;
         den_ff[0] <= in_den;
         ovf_ff[0] <= (in_num >= (NW'(in_den) << W));
         tag_ff[0] <= in_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   for (genvar k = 1; k <= W; k++) begin : g_step
      localparam int I = W - k;
      logic [NW-1:0] shifted;
      logic          ge;
      logic [W-1:0]  q_prev;
      logic [W-1:0]  q_in;

      // Try to subtract the shifted divisor
      always_comb begin
         shifted = NW'(den_ff[k-1]) << I;
         ge      = (rem_ff[k-1] >= shifted);
         q_in    = q_prev | (W'(ge) << I);
      end

      if (k == 1) begin : g_first
         assign q_prev = '0;
      end else begin : g_rest
         assign q_prev = q_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[k]   <= q_in;
            ovf_ff[k] <= ovf_ff[k-1];
            tag_ff[k] <= tag_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_ff[k-1];
         end
      end

      if (k < W) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= ge ? rem_ff[k-1] - shifted : rem_ff[k-1];
               den_ff[k] <= den_ff[k-1];
            end
         end
      end
   end

   assign out_valid = v_ff[W];
   assign out_quot  = q_ff[W];
   assign out_ovf   = ovf_ff[W];
   assign out_tag   = tag_ff[W];

endmodule

// ===== hdl/sli_back.sv =====
// Back: Cramer numerators, division, saturation and the segment hit test.
module sli_back #(
   parameter int COORD_WIDTH = sli_pkg::COORD_WIDTH,
   localparam int W  = COORD_WIDTH,
   localparam int PW = sli_pkg::PORT_WIDTH,
   localparam int AW = W + 1,
   localparam int CW = 2 * W + 2,
   localparam int DW = 2 * W + 3,
   localparam int NW = 3 * W + 5,
   localparam int LB = W + 1,
   localparam int HW = CW - LB,
   localparam int EW = 4 * AW + 2 * CW + DW + 1 + 4 * W,
   localparam int TX = 4 * W + 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  sli_pkg::q_status_type   q_status,
   input  logic [EW-1:0]           pop_data,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_hit,
   output logic                    rsp_parallel,
   output logic signed [PW-1:0]    rsp_cross_x,
   output logic signed [PW-1:0]    rsp_cross_y
);

   localparam logic [W-1:0] LIM_POS = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] LIM_NEG = {1'b1, {(W-1){1'b0}}};

   logic be;

   // Queue entry fields
   logic signed [AW-1:0] a1, b1, a2, b2;
   logic signed [CW-1:0] c1, c2;
   logic signed [DW-1:0] det;
   logic                 par;
   logic signed [W-1:0]  sx, sy, ex, ey;
   logic signed [LB:0]   c1lo, c2lo;
   logic signed [HW-1:0] c1hi, c2hi;

   // Stage 1: partial products
   logic                   v1_ff;
   logic signed [DW-1:0]   det1_ff;
   logic                   par1_ff;
   logic signed [W-1:0]    sx1_ff, sy1_ff, ex1_ff, ey1_ff;
   logic signed [AW+LB:0]  cx1_in, cx3_in, cy1_in, cy3_in;
   logic signed [AW+LB:0]  cx1_ff, cx3_ff, cy1_ff, cy3_ff;
   logic signed [AW+HW-1:0] cx2_in, cx4_in, cy2_in, cy4_in;
   logic signed [AW+HW-1:0] cx2_ff, cx4_ff, cy2_ff, cy4_ff;

   // Stage 2: numerators
   logic                   v2_ff;
   logic signed [DW-1:0]   det2_ff;
   logic                   par2_ff;
   logic signed [W-1:0]    sx2_ff, sy2_ff, ex2_ff, ey2_ff;
   logic signed [NW-1:0]   nx_in, ny_in, nx_ff, ny_ff;

   // Stage 3: magnitudes and signs
   logic                   v3_ff;
   logic [NW-1:0]          magx_in, magy_in, magx_ff, magy_ff;
   logic [DW-1:0]          dmag_in, dmag_ff;
   logic                   negx_ff, negy_ff, par3_ff;
   logic signed [W-1:0]    sx3_ff, sy3_ff, ex3_ff, ey3_ff;

   // Divider outputs
   logic                   dvx_valid, dvy_valid;
   logic [W-1:0]           qx, qy;
   logic                   ovfx, ovfy;
   logic [TX-1:0]          tagx;
   logic                   tagy;
   logic                   dpar, dnegx, dnegy;
   logic signed [W-1:0]    dsx, dsy, dex, dey;

   // Stage S: saturated point and box limits
   logic                   vs_ff;
   logic [W-1:0]           mx, my, px_in, py_in;
   logic signed [W-1:0]    px_ff, py_ff;
   logic                   pars_ff;
   logic signed [W-1:0]    xlo_in, xhi_in, ylo_in, yhi_in;
   logic signed [W-1:0]    xlo_ff, xhi_ff, ylo_ff, yhi_ff, exs_ff, eys_ff;

   // Output register
   logic                   ov_ff;
   logic                   hit_in, hit_ff, opar_ff;
   logic signed [PW-1:0]   ox_in, oy_in, ox_ff, oy_ff;

   // Freeze the back while a result waits on a stalled output
   assign be  = !(ov_ff && rsp_stall);
   assign pop = be && !q_status.empty;

   assign {a1, b1, a2, b2, c1, c2, det, par, sx, sy, ex, ey} = pop_data;
   assign c1lo = {1'b0, c1[LB-1:0]};
   assign c2lo = {1'b0, c2[LB-1:0]};
   assign c1hi = c1[CW-1:LB];
   assign c2hi = c2[CW-1:LB];

   // Split the constants so each product stays narrow
   always_comb begin
      cx1_in = b2 * c1lo;
      cx2_in = b2 * c1hi;
      cx3_in = b1 * c2lo;
      cx4_in = b1 * c2hi;
      cy1_in = a1 * c2lo;
      cy2_in = a1 * c2hi;
      cy3_in = a2 * c1lo;
      cy4_in = a2 * c1hi;
   end

   // Recombine into the two numerators
   always_comb begin
      nx_in = ((NW'(cx2_ff) - NW'(cx4_ff)) <<< LB) + NW'(cx1_ff) - NW'(cx3_ff);
      ny_in = ((NW'(cy2_ff) - NW'(cy4_ff)) <<< LB) + NW'(cy1_ff) - NW'(cy3_ff);
   end

   always_comb begin
      magx_in = nx_ff[NW-1] ? -nx_ff : nx_ff;
      magy_in = ny_ff[NW-1] ? -ny_ff : ny_ff;
      dmag_in = det2_ff[DW-1] ? -det2_ff : det2_ff;
   end

   always_ff @(posedge clock) begin
      if (be) begin
         cx1_ff  <= cx1_in;
         cx2_ff  <= cx2_in;
         cx3_ff  <= cx3_in;
         cx4_ff  <= cx4_in;
         cy1_ff  <= cy1_in;
         cy2_ff  <= cy2_in;
         cy3_ff  <= cy3_in;
         cy4_ff  <= cy4_in;
         det1_ff <= det;
         par1_ff <= par;
         sx1_ff  <= sx;
         sy1_ff  <= sy;
         ex1_ff  <= ex;
         ey1_ff  <= ey;

         nx_ff   <= nx_in;
         ny_ff   <= ny_in;
         det2_ff <= det1_ff;
         par2_ff <= par1_ff;
         sx2_ff  <= sx1_ff;
         sy2_ff  <= sy1_ff;
         ex2_ff  <= ex1_ff;
         ey2_ff  <= ey1_ff;

         magx_ff <= magx_in;
         magy_ff <= magy_in;
         dmag_ff <= dmag_in;
         negx_ff <= nx_ff[NW-1] ^ det2_ff[DW-1];
         negy_ff <= ny_ff[NW-1] ^ det2_ff[DW-1];
         par3_ff <= par2_ff;
         sx3_ff  <= sx2_ff;
         sy3_ff  <= sy2_ff;
         ex3_ff  <= ex2_ff;
         ey3_ff  <= ey2_ff;
      end
   end

   sli_div #(
      .COORD_WIDTH (W),
      .TAG_W       (TX)
   ) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .en        (be),
      .in_valid  (v3_ff),
      .in_num    (magx_ff),
      .in_den    (dmag_ff),
      .in_tag    ({par3_ff, sx3_ff, sy3_ff, ex3_ff, ey3_ff, negx_ff}),
      .out_valid (dvx_valid),
      .out_quot  (qx),
      .out_ovf   (ovfx),
      .out_tag   (tagx)
   );

   sli_div #(
      .COORD_WIDTH (W),
      .TAG_W       (1)
   ) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .en        (be),
      .in_valid  (v3_ff),
      .in_num    (magy_ff),
      .in_den    (dmag_ff),
      .in_tag    (negy_ff),
      .out_valid (dvy_valid),
      .out_quot  (qy),
      .out_ovf   (ovfy),
      .out_tag   (tagy)
   );

   assign {dpar, dsx, dsy, dex, dey, dnegx} = tagx;
   assign dnegy = tagy;

   // Saturate toward the signed coordinate range
   always_comb begin
      if (dnegx) begin
         mx = (ovfx || qx > LIM_NEG) ? LIM_NEG : qx;
      end else begin
         mx = (ovfx || qx > LIM_POS) ? LIM_POS : qx;
      end
      if (dnegy) begin
         my = (ovfy || qy > LIM_NEG) ? LIM_NEG : qy;
      end else begin
         my = (ovfy || qy > LIM_POS) ? LIM_POS : qy;
      end
      px_in  = dnegx ? -mx : mx;
      py_in  = dnegy ? -my : my;
      xlo_in = (dsx < dex) ? dsx : dex;
      xhi_in = (dsx < dex) ? dex : dsx;
      ylo_in = (dsy < dey) ? dsy : dey;
      yhi_in = (dsy < dey) ? dey : dsy;
   end

   always_ff @(posedge clock) begin
      if (be) begin
         px_ff   <= px_in;
         py_ff   <= py_in;
         pars_ff <= dpar;
         xlo_ff  <= xlo_in;
         xhi_ff  <= xhi_in;
         ylo_ff  <= ylo_in;
         yhi_ff  <= yhi_in;
         exs_ff  <= dex;
         eys_ff  <= dey;
      end
   end

   // Hit test: not parallel, inside the box, end point excluded
   always_comb begin
      hit_in = !pars_ff && !(px_ff == exs_ff && py_ff == eys_ff) &&
               xlo_ff <= px_ff && px_ff <= xhi_ff &&
               ylo_ff <= py_ff && py_ff <= yhi_ff;
      ox_in  = pars_ff ? '0 : PW'(px_ff);
      oy_in  = pars_ff ? '0 : PW'(py_ff);
   end

   always_ff @(posedge clock) begin
      if (be) begin
         hit_ff  <= hit_in;
         opar_ff <= pars_ff;
         ox_ff   <= ox_in;
         oy_ff   <= oy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vs_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else if (be) begin
         v1_ff <= pop;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         vs_ff <= dvx_valid && dvy_valid;
         ov_ff <= vs_ff;
      end
   end

   assign rsp_valid    = ov_ff;
   assign rsp_hit      = hit_ff;
   assign rsp_parallel = opar_ff;
   assign rsp_cross_x  = ox_ff;
   assign rsp_cross_y  = oy_ff;

endmodule

// ===== hdl/segment_line_intersection_top.sv =====
// Segment against infinite line intersection: top level.
// Takes one request per clock while req_stall is low and returns one response per
// request, in order. Three front stages form the line equations and determinant,
// the request passes a QUEUE_DEPTH entry queue, then three stages form the Cramer
// numerators, two restoring dividers take COORD_WIDTH + 1 stages each (an overflow
// check, then one quotient bit per stage), and two stages saturate, run the hit
// test and hold the response. A stalled response freezes the back part; the front
// keeps taking requests until the queue fills.
module segment_line_intersection_top #(
   parameter int COORD_WIDTH = sli_pkg::COORD_WIDTH,
   parameter int QUEUE_DEPTH = sli_pkg::QUEUE_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [sli_pkg::PORT_WIDTH-1:0] req_seg_start_x,
   input  logic signed [sli_pkg::PORT_WIDTH-1:0] req_seg_start_y,
   input  logic signed [sli_pkg::PORT_WIDTH-1:0] req_seg_end_x,
   input  logic signed [sli_pkg::PORT_WIDTH-1:0] req_seg_end_y,
   input  logic signed [sli_pkg::PORT_WIDTH-1:0] req_line_a_x,
   input  logic signed [sli_pkg::PORT_WIDTH-1:0] req_line_a_y,
   input  logic signed [sli_pkg::PORT_WIDTH-1:0] req_line_b_x,
   input  logic signed [sli_pkg::PORT_WIDTH-1:0] req_line_b_y,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_hit,
   output logic                                  rsp_parallel,
   output logic signed [sli_pkg::PORT_WIDTH-1:0] rsp_cross_x,
   output logic signed [sli_pkg::PORT_WIDTH-1:0] rsp_cross_y
);

   localparam int W  = COORD_WIDTH;
   localparam int EW = 4 * (W + 1) + 2 * (2 * W + 2) + (2 * W + 3) + 1 + 4 * W;

   sli_pkg::q_status_type q_status;
   logic                  push, pop;
   logic [EW-1:0]         push_data, pop_data;

   sli_front #(
      .COORD_WIDTH (W)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_seg_start_x (req_seg_start_x),
      .req_seg_start_y (req_seg_start_y),
      .req_seg_end_x   (req_seg_end_x),
      .req_seg_end_y   (req_seg_end_y),
      .req_line_a_x    (req_line_a_x),
      .req_line_a_y    (req_line_a_y),
      .req_line_b_x    (req_line_b_x),
      .req_line_b_y    (req_line_b_y),
      .q_status        (q_status),
      .push            (push),
      .push_data       (push_data)
   );

   sli_queue #(
      .WIDTH (EW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   sli_back #(
      .COORD_WIDTH (W)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_status     (q_status),
      .pop_data     (pop_data),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_hit      (rsp_hit),
      .rsp_parallel (rsp_parallel),
      .rsp_cross_x  (rsp_cross_x),
      .rsp_cross_y  (rsp_cross_y)
   );

endmodule

// ===== hdl/sli_checker.sv =====
// Port-level checks for the intersection block, bound to the top level.
`include "assert_macros.svh"

module sli_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic signed [sli_pkg::PORT_WIDTH-1:0] req_seg_start_x,
   input logic signed [sli_pkg::PORT_WIDTH-1:0] req_seg_start_y,
   input logic signed [sli_pkg::PORT_WIDTH-1:0] req_seg_end_x,
   input logic signed [sli_pkg::PORT_WIDTH-1:0] req_seg_end_y,
   input logic signed [sli_pkg::PORT_WIDTH-1:0] req_line_a_x,
   input logic signed [sli_pkg::PORT_WIDTH-1:0] req_line_a_y,
   input logic signed [sli_pkg::PORT_WIDTH-1:0] req_line_b_x,
   input logic signed [sli_pkg::PORT_WIDTH-1:0] req_line_b_y,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic                                  rsp_hit,
   input logic                                  rsp_parallel,
   input logic signed [sli_pkg::PORT_WIDTH-1:0] rsp_cross_x,
   input logic signed [sli_pkg::PORT_WIDTH-1:0] rsp_cross_y
);

   property p_rsp_hold;
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cross_x) && $stable(rsp_cross_y) &&
                                 $stable(rsp_hit) && $stable(rsp_parallel);
   endproperty

   property p_par_no_hit;
      rsp_valid && rsp_parallel |-> !rsp_hit;
   endproperty

   property p_par_zero;
      rsp_valid && rsp_parallel |-> rsp_cross_x == 0 && rsp_cross_y == 0;
   endproperty

   // A stalled response holds
   `SLI_ASSERT(a_rsp_hold, clock, reset, p_rsp_hold, "stalled response changed")

   // Parallel inputs never hit
   `SLI_ASSERT(a_par_no_hit, clock, reset, p_par_no_hit, "hit on parallel response")

   // Parallel inputs give a zero point
   `SLI_ASSERT(a_par_zero, clock, reset, p_par_zero, "nonzero point on parallel response")

   // Reset drops any pending response
   `SLI_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid, "response valid after reset")

endmodule

bind segment_line_intersection_top sli_checker u_sli_checker (.*);
